// ----- design/tun_pkg.sv -----
`timescale 1ns / 1ps
package tun_pkg;
  localparam int COORD_WIDTH   = 16;
  localparam int FRACTION_BITS = 14;
  localparam int OUT_WIDTH     = 16;
  // magnitude width after normalising shift, and width of the sum of squares
  localparam int MAG_BITS      = 31;
  localparam int SUM_BITS      = 64;
endpackage

// ----- design/tun_in_if.sv -----
`timescale 1ns / 1ps
interface tun_in_if #(
  parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [COORD_WIDTH-1:0] point_a_x;
  logic signed [COORD_WIDTH-1:0] point_a_y;
  logic signed [COORD_WIDTH-1:0] point_a_z;
  logic signed [COORD_WIDTH-1:0] point_b_x;
  logic signed [COORD_WIDTH-1:0] point_b_y;
  logic signed [COORD_WIDTH-1:0] point_b_z;
  logic signed [COORD_WIDTH-1:0] point_c_x;
  logic signed [COORD_WIDTH-1:0] point_c_y;
  logic signed [COORD_WIDTH-1:0] point_c_z;

  modport source (
    output valid, command, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
           point_b_z, point_c_x, point_c_y, point_c_z,
    input  ready
  );
  modport sink (
    input  valid, command, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
           point_b_z, point_c_x, point_c_y, point_c_z,
    output ready
  );
endinterface

// ----- design/tun_out_if.sv -----
`timescale 1ns / 1ps
interface tun_out_if ();
  logic                                   valid;
  logic                                   ready;
  logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_x;
  logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_y;
  logic signed [tun_pkg::OUT_WIDTH-1:0]   normal_z;
  logic                                   degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

// ----- design/triangle_unit_normal_top.sv -----
`timescale 1ns / 1ps
// channel | dir | payload                                   | handshake
// pts     | in  | command, point_a/b/c_x/y/z                | valid/ready
// nrm     | out | normal_x/y/z (q2.14), degenerate          | valid/ready
//
// fully pipelined: one item per cycle while the output is not stalled
// the depth is set by the per-bit search stages of the three root lanes
// reset clears the valid bits only; payload stages run without reset
// a held result stalls every stage together; pts.ready drops only then
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH,
  parameter int FRACTION_BITS = tun_pkg::FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst,
  tun_in_if.sink    pts,
  tun_out_if.source nrm
);
  localparam int W   = COORD_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int PW  = 2 * W + 2;             // product width
  localparam int NW  = PW + 1;                // cross term width
  localparam int MB  = tun_pkg::MAG_BITS;
  localparam int EW  = (NW > MB) ? NW : MB;   // magnitude width before the shift
  localparam int LW  = $clog2(EW + 1);
  localparam int NST = F + 9;                 // last stage, aligned with lane output
  localparam int OW  = tun_pkg::OUT_WIDTH;
  localparam int OQW = (F + 2 > OW) ? F + 2 : OW;

  logic en;
  assign en        = !nrm.valid || nrm.ready;
  assign pts.ready = en;

  // valid and side bits travel alongside the data
  logic       vld [1:NST];
  logic [2:0] sgn [4:NST];
  logic       dg  [4:NST];

  // stage 1: edge vectors (or the raw vectors in vector mode)
  logic signed [W-1:0] pa [3];
  logic signed [W-1:0] pb [3];
  logic signed [W-1:0] pc [3];
  logic signed [W:0]   x1 [3];
  logic signed [W:0]   y1 [3];

  always_comb begin
    pa[0] = pts.point_a_x; pa[1] = pts.point_a_y; pa[2] = pts.point_a_z;
    pb[0] = pts.point_b_x; pb[1] = pts.point_b_y; pb[2] = pts.point_b_z;
    pc[0] = pts.point_c_x; pc[1] = pts.point_c_y; pc[2] = pts.point_c_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x1[i] <= pts.command ? (W + 1)'(pa[i]) - (W + 1)'(pb[i]) : (W + 1)'(pa[i]);
        y1[i] <= pts.command ? (W + 1)'(pb[i]) - (W + 1)'(pc[i]) : (W + 1)'(pb[i]);
      end
    end
  end

  // stage 2: the six partial products of the cross product
  logic signed [PW-1:0] p2 [6];
  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= x1[1] * y1[2];
      p2[1] <= x1[2] * y1[1];
      p2[2] <= x1[2] * y1[0];
      p2[3] <= x1[0] * y1[2];
      p2[4] <= x1[0] * y1[1];
      p2[5] <= x1[1] * y1[0];
    end
  end

  // stage 3: exact cross product
  logic signed [NW-1:0] n3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n3[i] <= NW'(p2[2*i]) - NW'(p2[2*i+1]);
      end
    end
  end

  // stage 4: sign and magnitude, zero check
  logic [NW-1:0] mag4 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn[4][i] <= n3[i][NW-1];
        mag4[i]   <= n3[i][NW-1] ? NW'(-n3[i]) : NW'(n3[i]);
      end
      dg[4] <= (n3[0] == '0) && (n3[1] == '0) && (n3[2] == '0);
    end
  end

  // stage 5: common truncating shift so every magnitude fits below 2^31
  logic [EW-1:0] mor;
  logic [LW-1:0] mlen;
  logic [LW-1:0] msh;
  logic [MB-1:0] m5 [3];

  always_comb begin
    mor  = EW'(mag4[0] | mag4[1] | mag4[2]);
    mlen = '0;
    for (int j = 0; j < EW; j++) begin
      if (mor[j]) mlen = LW'(j + 1);
    end
    msh = (mlen > LW'(MB)) ? mlen - LW'(MB) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m5[i] <= MB'(EW'(mag4[i]) >> msh);
      end
    end
  end

  // stage 6: squares
  logic [2*MB-1:0] sq6 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq6[i] <= m5[i] * m5[i];
    end
  end

  // stage 7: sum of squares
  logic [tun_pkg::SUM_BITS-1:0] s7;
  logic [2*MB-1:0]              sq7 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s7 <= tun_pkg::SUM_BITS'(sq6[0]) + tun_pkg::SUM_BITS'(sq6[1])
          + tun_pkg::SUM_BITS'(sq6[2]);
      for (int i = 0; i < 3; i++) sq7[i] <= sq6[i];
    end
  end

  // stages 8 to NST: one root lane per component
  logic [F:0] qr [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    tun_root #(.FRACTION_BITS(F)) u_root (
      .clk (clk),
      .en  (en),
      .sum (s7),
      .sq  (sq7[c]),
      .q   (qr[c])
    );
  end

  // valid chain with reset, side bits without
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= NST; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[1] <= pts.valid;
      for (int j = 2; j <= NST; j++) vld[j] <= vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 5; j <= NST; j++) begin
        sgn[j] <= sgn[j-1];
        dg[j]  <= dg[j-1];
      end
    end
  end

  // output register: apply signs, zero a degenerate item
  logic signed [F+1:0]  qs [3];
  logic signed [OQW-1:0] qe [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({1'b0, qr[i]});
      qe[i] = sgn[NST][i] ? OQW'(-qs[i]) : OQW'(qs[i]);
      if (dg[NST]) qe[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm.valid <= 1'b0;
    end else if (en) begin
      nrm.valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm.normal_x   <= qe[0][OW-1:0];
      nrm.normal_y   <= qe[1][OW-1:0];
      nrm.normal_z   <= qe[2][OW-1:0];
      nrm.degenerate <= dg[NST];
    end
  end
endmodule

// ----- design/tun_root.sv -----
`timescale 1ns / 1ps
// one component: bit-serial search for the rounded m*2^f/sqrt(s), one bit per stage
module tun_root #(
  parameter int FRACTION_BITS = tun_pkg::FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [tun_pkg::SUM_BITS-1:0]        sum,
  input  logic [2*tun_pkg::MAG_BITS-1:0]      sq,
  output logic [FRACTION_BITS:0]              q
);
  localparam int F  = FRACTION_BITS;
  localparam int DW = 2 * F + 70;

  logic signed [DW-1:0] dd [0:F+1];
  logic signed [DW-1:0] qq [0:F+1];
  logic signed [DW-1:0] ss [0:F+1];
  logic [F:0]           qv [0:F+1];

  // remainder starts at m^2*2^(2f+2) minus s, since candidate q=0 gives (2q-1)^2 = 1
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= ($signed(DW'(sq)) <<< (2 * F + 2)) - $signed(DW'(sum));
      qq[0] <= -$signed(DW'(sum));
      ss[0] <= $signed(DW'(sum));
      qv[0] <= '0;
    end
  end

  for (genvar g = 0; g <= F; g++) begin : g_step
    localparam int K = F - g;
    logic signed [DW-1:0] t;
    logic                 take;
    assign t    = (qq[g] <<< (K + 2)) + (ss[g] <<< (2 * K + 2));
    assign take = (t <= dd[g]);
    always_ff @(posedge clk) begin
      if (en) begin
        dd[g+1] <= take ? dd[g] - t : dd[g];
        qq[g+1] <= take ? qq[g] + (ss[g] <<< (K + 1)) : qq[g];
        ss[g+1] <= ss[g];
        qv[g+1] <= qv[g] | ((F + 1)'(take) << K);
      end
    end
  end

  assign q = qv[F+1];
endmodule

// ----- design/tun_check.sv -----
`timescale 1ns / 1ps
module tun_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tun_pkg::OUT_WIDTH-1:0]   normal_x,
  input logic [tun_pkg::OUT_WIDTH-1:0]   normal_y,
  input logic [tun_pkg::OUT_WIDTH-1:0]   normal_z,
  input logic                            degenerate
);
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate item with nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("non-degenerate item with zero normal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(degenerate))
    else $error("stalled item changed");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind triangle_unit_normal_top tun_check u_tun_check (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pts.ready),
  .out_valid  (nrm.valid),
  .out_ready  (nrm.ready),
  .normal_x   (nrm.normal_x),
  .normal_y   (nrm.normal_y),
  .normal_z   (nrm.normal_z),
  .degenerate (nrm.degenerate)
);
